// ===== sv/bpip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bpip_pkg;

  localparam int COORD_W   = 16;
  localparam int OPND_W    = 18;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = 36;
  localparam int WEIGHT_W  = 17;
  localparam int RES_W     = 11;
  localparam int SAMPLES   = 15;
  localparam int SAMP_W    = 4;
  localparam int RAY_MARGIN = 160;
  localparam int ROUND_HALF = 32768;
  localparam int FRAC_SHIFT = 16;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_MUL,
    ST_Q_FIRST,
    ST_Q_FETCH,
    ST_Q_M1,
    ST_Q_M2,
    ST_Q_M3,
    ST_Q_EV
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // rounded bernstein weights, q1.16, sample i by control point k
  localparam logic [WEIGHT_W-1:0] WEIGHT [0:SAMPLES-1][0:3] = '{
    '{17'd65536, 17'd0,     17'd0,     17'd0    },
    '{17'd53283, 17'd11418, 17'd816,   17'd19   },
    '{17'd42662, 17'd19690, 17'd3029,  17'd155  },
    '{17'd33554, 17'd25166, 17'd6291,  17'd524  },
    '{17'd25845, 17'd28195, 17'd10253, 17'd1243 },
    '{17'd19418, 17'd29127, 17'd14564, 17'd2427 },
    '{17'd14156, 17'd28312, 17'd18874, 17'd4194 },
    '{17'd9942,  17'd26098, 17'd22836, 17'd6660 },
    '{17'd6660,  17'd22836, 17'd26098, 17'd9942 },
    '{17'd4194,  17'd18874, 17'd28312, 17'd14156},
    '{17'd2427,  17'd14564, 17'd29127, 17'd19418},
    '{17'd1243,  17'd10253, 17'd28195, 17'd25845},
    '{17'd524,   17'd6291,  17'd25166, 17'd33554},
    '{17'd155,   17'd3029,  17'd19690, 17'd42662},
    '{17'd19,    17'd816,   17'd11418, 17'd53283}
  };

endpackage
`default_nettype wire

// ===== sv/bpip_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bpip_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl0_x;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl0_y;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl1_x;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl1_y;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl2_x;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl2_y;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl3_x;
  logic signed [bpip_pkg::COORD_W-1:0] ctrl3_y;
  logic signed [bpip_pkg::COORD_W-1:0] query_x;
  logic signed [bpip_pkg::COORD_W-1:0] query_y;
  modport source (output valid, func, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  ctrl3_x, ctrl3_y, query_x, query_y, input ready);
  modport sink (input valid, func, ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                ctrl3_x, ctrl3_y, query_x, query_y, output ready);
endinterface

interface bpip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic [bpip_pkg::RES_W-1:0] crossings;
  logic [bpip_pkg::RES_W-1:0] points_stored;
  logic overflow;
  modport source (output valid, inside_res, crossings, points_stored, overflow, input ready);
  modport sink (input valid, inside_res, crossings, points_stored, overflow, output ready);
endinterface
`default_nettype wire

// ===== sv/bpip_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== sv/bpip_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bpip_mul (
  input  wire logic                                clk,
  input  wire logic signed [bpip_pkg::OPND_W-1:0]  opa,
  input  wire logic signed [bpip_pkg::OPND_W-1:0]  opb,
  output logic signed [bpip_pkg::PROD_W-1:0]       prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end
endmodule
`default_nettype wire

// ===== sv/bezier_polygon_point_inside_test_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// clear, unused code and a query on fewer than two points: result valid in the cycle after transfer
// append: 15 samples, each x then y (one shared multiplier, 4 weights per coordinate)
// query on n >= 2 points: each edge is fetched, multiplied three times and evaluated; the closing edge needs no fetch
// one item at a time; a new transfer is taken once the result has been taken
// reset clears the sequencer, result valid, point count and minimum x; store contents stay undefined
module bezier_polygon_point_inside_test_unit #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bpip_in_if.sink     in_chan,
  bpip_out_if.source  out_chan
);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CORD = bpip_pkg::COORD_W;
  localparam int OW = bpip_pkg::OPND_W;
  localparam int PW = bpip_pkg::PROD_W;
  localparam int AC = bpip_pkg::ACC_W;
  localparam int VW = AC - bpip_pkg::FRAC_SHIFT;
  localparam int RW = bpip_pkg::RES_W;
  localparam logic signed [CORD-1:0] CMAX = {1'b0, {(CORD-1){1'b1}}};
  localparam logic signed [CORD-1:0] CMIN = {1'b1, {(CORD-1){1'b0}}};

  bpip_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [CORD-1:0] minx_r, minx_nxt;
  logic signed [CORD-1:0] px_r [0:3];
  logic signed [CORD-1:0] py_r [0:3];
  logic signed [CORD-1:0] qx_r, qy_r;
  logic load_ctrl, load_q;
  logic [bpip_pkg::SAMP_W-1:0] samp_r, samp_nxt;
  logic [2:0] step_r, step_nxt;
  logic coord_r, coord_nxt;
  logic signed [AC-1:0] acc_r, acc_nxt;
  logic signed [CORD-1:0] sx_r, sx_nxt;
  logic ovf_r, ovf_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  bpip_pkg::point_t a_r, a_nxt, first_r, first_nxt, b_pt, rd_pt;
  logic closing_r, closing_nxt;
  logic signed [PW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic [CW-1:0] xing_r, xing_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_inside_r, out_inside_nxt, out_ovf_r, out_ovf_nxt;
  logic [RW-1:0] out_xing_r, out_xing_nxt, out_pts_r, out_pts_nxt;

  logic wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_data;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  logic in_xfer;
  logic signed [AC-1:0] total;
  logic signed [VW-1:0] val;
  logic signed [CORD-1:0] sat;
  logic signed [CORD-1:0] ctrl_sel;
  logic signed [OW-1:0] ex, dqx, dex, v6x, v6y, dqy, v3x;
  logic signed [PW:0] n3, n4;
  logic in_range, horiz, s12lt, s12le, s34lt, s34le, counted;
  logic full;

  assign in_xfer = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == bpip_pkg::ST_IDLE) && !out_valid_r;
  assign out_chan.valid = out_valid_r;
  assign out_chan.inside_res = out_inside_r;
  assign out_chan.crossings = out_xing_r;
  assign out_chan.points_stored = out_pts_r;
  assign out_chan.overflow = out_ovf_r;

  bpip_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt_r[AW-1:0]), .wr_data({sx_r, sat}),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  bpip_mul u_mul (.clk(clk), .opa(mul_a), .opb(mul_b), .prod_r(mul_p));

  // sample finish
  assign ctrl_sel = coord_r ? py_r[step_r[1:0]] : px_r[step_r[1:0]];
  assign total = acc_r + AC'(mul_p) + AC'(bpip_pkg::ROUND_HALF);
  assign val = total[AC-1:bpip_pkg::FRAC_SHIFT];
  always_comb begin
    if (val > VW'(CMAX)) begin
      sat = CMAX;
    end else if (val < VW'(CMIN)) begin
      sat = CMIN;
    end else begin
      sat = val[CORD-1:0];
    end
  end
  assign full = cnt_r >= CW'(MAX_POINTS);

  // edge test
  assign rd_pt = rd_data;
  assign b_pt = closing_r ? first_r : rd_pt;
  assign ex = OW'(minx_r) - OW'(bpip_pkg::RAY_MARGIN);
  assign dqx = OW'(qx_r) - OW'(a_r.x);
  assign dex = ex - OW'(a_r.x);
  assign v6x = OW'(b_pt.x) - OW'(a_r.x);
  assign v6y = OW'(b_pt.y) - OW'(a_r.y);
  assign dqy = OW'(qy_r) - OW'(a_r.y);
  assign v3x = ex - OW'(qx_r);
  assign n3 = (PW+1)'(p1_r) - (PW+1)'(mul_p);
  assign n4 = (PW+1)'(p2_r) - (PW+1)'(mul_p);
  assign in_range = ((qy_r >= a_r.y) && (qy_r <= b_pt.y)) ||
                    ((qy_r >= b_pt.y) && (qy_r <= a_r.y));
  assign horiz = a_r.y == b_pt.y;
  assign s12lt = (v3x != 0) && (a_r.y != qy_r) && (b_pt.y != qy_r) &&
                 ((a_r.y < qy_r) != (b_pt.y < qy_r));
  assign s12le = s12lt || (v3x == 0) || (a_r.y == qy_r) || (b_pt.y == qy_r);
  assign s34lt = (n3 != 0) && (n4 != 0) && (n3[PW] != n4[PW]);
  assign s34le = s34lt || (n3 == 0) || (n4 == 0);
  assign counted = in_range && !horiz && ((s12le && s34lt) || (s34le && s12lt));

  assign load_ctrl = in_xfer && (in_chan.func == bpip_pkg::FUNC_APPEND);
  assign load_q = in_xfer && (in_chan.func == bpip_pkg::FUNC_QUERY);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    minx_nxt = minx_r;
    samp_nxt = samp_r;
    step_nxt = step_r;
    coord_nxt = coord_r;
    acc_nxt = acc_r;
    sx_nxt = sx_r;
    ovf_nxt = ovf_r;
    idx_nxt = idx_r;
    a_nxt = a_r;
    first_nxt = first_r;
    closing_nxt = closing_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    xing_nxt = xing_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_inside_nxt = out_inside_r;
    out_xing_nxt = out_xing_r;
    out_pts_nxt = out_pts_r;
    out_ovf_nxt = out_ovf_r;
    wr_en = 1'b0;
    rd_en = 1'b0;
    rd_addr = idx_r[AW-1:0];
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      bpip_pkg::ST_IDLE: begin
        if (in_xfer) begin
          out_inside_nxt = 1'b0;
          out_xing_nxt = '0;
          out_ovf_nxt = 1'b0;
          out_pts_nxt = RW'(cnt_r);
          unique case (in_chan.func)
            bpip_pkg::FUNC_CLEAR: begin
              cnt_nxt = '0;
              minx_nxt = CMAX;
              out_pts_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            bpip_pkg::FUNC_APPEND: begin
              samp_nxt = '0;
              step_nxt = '0;
              coord_nxt = 1'b0;
              acc_nxt = '0;
              ovf_nxt = 1'b0;
              state_nxt = bpip_pkg::ST_A_MUL;
            end
            bpip_pkg::FUNC_QUERY: begin
              if (cnt_r < CW'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en = 1'b1;
                rd_addr = '0;
                idx_nxt = CW'(1);
                xing_nxt = '0;
                closing_nxt = 1'b0;
                state_nxt = bpip_pkg::ST_Q_FIRST;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      bpip_pkg::ST_A_MUL: begin
        if (step_r != 3'd4) begin
          mul_a = OW'({1'b0, bpip_pkg::WEIGHT[samp_r][step_r[1:0]]});
          mul_b = OW'(ctrl_sel);
          step_nxt = step_r + 3'd1;
          if (step_r != 3'd0) begin
            acc_nxt = acc_r + AC'(mul_p);
          end
        end else begin
          step_nxt = '0;
          acc_nxt = '0;
          coord_nxt = !coord_r;
          if (!coord_r) begin
            sx_nxt = sat;
          end else begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              if (sx_r < minx_r) begin
                minx_nxt = sx_r;
              end
            end
            samp_nxt = samp_r + bpip_pkg::SAMP_W'(1);
            if (samp_r == bpip_pkg::SAMP_W'(bpip_pkg::SAMPLES - 1)) begin
              out_pts_nxt = RW'(cnt_nxt);
              out_ovf_nxt = ovf_nxt;
              out_valid_nxt = 1'b1;
              state_nxt = bpip_pkg::ST_IDLE;
            end
          end
        end
      end
      bpip_pkg::ST_Q_FIRST: begin
        first_nxt = rd_pt;
        a_nxt = rd_pt;
        rd_en = 1'b1;
        state_nxt = bpip_pkg::ST_Q_M1;
      end
      bpip_pkg::ST_Q_FETCH: begin
        rd_en = 1'b1;
        state_nxt = bpip_pkg::ST_Q_M1;
      end
      bpip_pkg::ST_Q_M1: begin
        mul_a = dqx;
        mul_b = v6y;
        state_nxt = bpip_pkg::ST_Q_M2;
      end
      bpip_pkg::ST_Q_M2: begin
        p1_nxt = mul_p;
        mul_a = dex;
        mul_b = v6y;
        state_nxt = bpip_pkg::ST_Q_M3;
      end
      bpip_pkg::ST_Q_M3: begin
        p2_nxt = mul_p;
        mul_a = v6x;
        mul_b = dqy;
        state_nxt = bpip_pkg::ST_Q_EV;
      end
      bpip_pkg::ST_Q_EV: begin
        if (counted) begin
          xing_nxt = xing_r + CW'(1);
        end
        if (closing_r) begin
          out_inside_nxt = xing_nxt[0];
          out_xing_nxt = RW'(xing_nxt);
          out_valid_nxt = 1'b1;
          state_nxt = bpip_pkg::ST_IDLE;
        end else begin
          a_nxt = b_pt;
          if (idx_r == cnt_r - CW'(1)) begin
            closing_nxt = 1'b1;
            state_nxt = bpip_pkg::ST_Q_M1;
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = bpip_pkg::ST_Q_FETCH;
          end
        end
      end
      default: begin
        state_nxt = bpip_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpip_pkg::ST_IDLE;
      cnt_r <= '0;
      minx_r <= CMAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      minx_r <= minx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r <= samp_nxt;
    step_r <= step_nxt;
    coord_r <= coord_nxt;
    acc_r <= acc_nxt;
    sx_r <= sx_nxt;
    ovf_r <= ovf_nxt;
    idx_r <= idx_nxt;
    a_r <= a_nxt;
    first_r <= first_nxt;
    closing_r <= closing_nxt;
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
    xing_r <= xing_nxt;
    out_inside_r <= out_inside_nxt;
    out_xing_r <= out_xing_nxt;
    out_pts_r <= out_pts_nxt;
    out_ovf_r <= out_ovf_nxt;
    if (load_ctrl) begin
      px_r[0] <= in_chan.ctrl0_x;
      py_r[0] <= in_chan.ctrl0_y;
      px_r[1] <= in_chan.ctrl1_x;
      py_r[1] <= in_chan.ctrl1_y;
      px_r[2] <= in_chan.ctrl2_x;
      py_r[2] <= in_chan.ctrl2_y;
      px_r[3] <= in_chan.ctrl3_x;
      py_r[3] <= in_chan.ctrl3_y;
    end
    if (load_q) begin
      qx_r <= in_chan.query_x;
      qy_r <= in_chan.query_y;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_valid_r && (state_r == bpip_pkg::ST_IDLE))
    else $error("input taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_inside_r == out_xing_r[0]))
    else $error("inside flag disagrees with crossing parity");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_xing_r))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// ===== tb/bpip_checker.sv =====
`timescale 1ns / 1ps
module bpip_checker (
  input  logic clk,
  input  logic rst_n,
  bpip_in_if   in_mon,
  bpip_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  localparam int STORE_DEPTH = 1024;
  localparam longint COORD_HI = 32767;
  localparam longint COORD_LO = -32768;

  typedef struct {
    logic                       inside_res;
    logic [bpip_pkg::RES_W-1:0] crossings;
    logic [bpip_pkg::RES_W-1:0] points_stored;
    logic                       overflow;
  } verdict_t;

  typedef longint quad_t [4];

  longint   poly_x [STORE_DEPTH];
  longint   poly_y [STORE_DEPTH];
  int       poly_len;
  longint   leftmost_x;
  verdict_t verdict_q [$];

  function automatic longint bern_w(int k, int i);
    longint num;
    num = (k == 0 || k == 3) ? 1 : 3;
    for (int j = 0; j < 3 - k; j++) num = num * (bpip_pkg::SAMPLES - i);
    for (int j = 0; j < k; j++) num = num * i;
    return (num * 65536 + 1687) / 3375;
  endfunction

  function automatic longint curve_coord(quad_t p, int i);
    longint acc;
    acc = 0;
    for (int k = 0; k < 4; k++) acc += bern_w(k, i) * p[k];
    acc = (acc + 32768) >>> 16;
    if (acc > COORD_HI) acc = COORD_HI;
    if (acc < COORD_LO) acc = COORD_LO;
    return acc;
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit ray_hits(longint ax, longint ay, longint bx, longint by,
                                  longint qx, longint qy, longint ex);
    longint lo, hi, dx, dy;
    int s12, s34;
    lo = (ay < by) ? ay : by;
    hi = (ay < by) ? by : ay;
    dx = bx - ax;
    dy = by - ay;
    if (qy > hi || qy < lo) return 0;
    if (ay == by) return 0;
    s12 = sgn(ex - qx) * sgn(ex - qx) * sgn(ay - qy) * sgn(by - qy);
    s34 = sgn((qx - ax) * dy - dx * (qy - ay)) * sgn((ex - ax) * dy - dx * (qy - ay));
    return (s12 <= 0 && s34 < 0) || (s34 <= 0 && s12 < 0);
  endfunction

  task automatic predict_polygon_result();
    verdict_t v;
    quad_t px, py;
    longint sx, sy, ex;
    int n;
    v = '{1'b0, '0, '0, 1'b0};
    if (in_mon.func == bpip_pkg::FUNC_CLEAR) begin
      poly_len = 0;
      leftmost_x = COORD_HI;
    end else if (in_mon.func == bpip_pkg::FUNC_APPEND) begin
      px = '{in_mon.ctrl0_x, in_mon.ctrl1_x, in_mon.ctrl2_x, in_mon.ctrl3_x};
      py = '{in_mon.ctrl0_y, in_mon.ctrl1_y, in_mon.ctrl2_y, in_mon.ctrl3_y};
      for (int i = 0; i < bpip_pkg::SAMPLES; i++) begin
        if (poly_len >= STORE_DEPTH) begin
          v.overflow = 1'b1;
        end else begin
          sx = curve_coord(px, i);
          sy = curve_coord(py, i);
          poly_x[poly_len] = sx;
          poly_y[poly_len] = sy;
          poly_len++;
          if (sx < leftmost_x) leftmost_x = sx;
        end
      end
    end else if (in_mon.func == bpip_pkg::FUNC_QUERY) begin
      ex = leftmost_x - bpip_pkg::RAY_MARGIN;
      n = 0;
      for (int i = 0; i + 1 < poly_len; i++)
        if (ray_hits(poly_x[i], poly_y[i], poly_x[i+1], poly_y[i+1],
                     in_mon.query_x, in_mon.query_y, ex)) n++;
      if (poly_len >= 2)
        if (ray_hits(poly_x[poly_len-1], poly_y[poly_len-1], poly_x[0], poly_y[0],
                     in_mon.query_x, in_mon.query_y, ex)) n++;
      v.crossings = n[bpip_pkg::RES_W-1:0];
      v.inside_res = n[0];
    end
    v.points_stored = poly_len[bpip_pkg::RES_W-1:0];
    verdict_q = {verdict_q, v};
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    verdict_t w;
    if (!rst_n) begin
      poly_len = 0;
      leftmost_x = COORD_HI;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = verdict_q.pop_front();
          if (out_mon.inside_res !== w.inside_res) report("inside_res", out_mon.inside_res, w.inside_res);
          if (out_mon.crossings !== w.crossings) report("crossings", out_mon.crossings, w.crossings);
          if (out_mon.points_stored !== w.points_stored)
            report("points_stored", out_mon.points_stored, w.points_stored);
          if (out_mon.overflow !== w.overflow) report("overflow", out_mon.overflow, w.overflow);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_polygon_result();
    end
    pending = verdict_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// ===== tb/bezier_polygon_point_inside_test_unit_tb.sv =====
`timescale 1ns / 1ps
module bezier_polygon_point_inside_test_unit_tb;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int ITEM_TARGET = 580;
  localparam int CYCLE_LIMIT = 3000000;

  typedef logic signed [bpip_pkg::COORD_W-1:0] coord_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  int   items;
  int   burst_left;
  bit   steady_send;
  int   stall_left;

  bpip_in_if  in_chan ();
  bpip_out_if out_chan ();

  bezier_polygon_point_inside_test_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bpip_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side stalls, with quiet windows
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_chan.ready = 1'b0;
      stall_left--;
    end else begin
      out_chan.ready = 1'b1;
      if ((cycles % 5000) > 1200 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  task automatic send(logic [1:0] f, coord_t cx[4], coord_t cy[4], coord_t qx, coord_t qy);
    int gap;
    if (burst_left == 0) begin
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_chan.func = f;
    in_chan.ctrl0_x = cx[0];
    in_chan.ctrl0_y = cy[0];
    in_chan.ctrl1_x = cx[1];
    in_chan.ctrl1_y = cy[1];
    in_chan.ctrl2_x = cx[2];
    in_chan.ctrl2_y = cy[2];
    in_chan.ctrl3_x = cx[3];
    in_chan.ctrl3_y = cy[3];
    in_chan.query_x = qx;
    in_chan.query_y = qy;
    in_chan.valid = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    items++;
  endtask

  function automatic coord_t near(coord_t c, int r);
    int v;
    v = int'(c) + $urandom_range(0, 2 * r) - r;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  task automatic send_loop(int curves, int r, bit tiny, output coord_t hx, output coord_t hy);
    coord_t cx[4], cy[4], fx, fy, lx, ly;
    int cxc, cyc;
    cxc = $urandom_range(0, 60000) - 30000;
    cyc = $urandom_range(0, 60000) - 30000;
    for (int c = 0; c < curves; c++) begin
      for (int k = 0; k < 4; k++) begin
        cx[k] = near(coord_t'(cxc), tiny ? 4 : r);
        cy[k] = near(coord_t'(cyc), tiny ? 4 : r);
      end
      if (c == 0) begin
        fx = cx[0];
        fy = cy[0];
      end else begin
        cx[0] = lx;
        cy[0] = ly;
      end
      if (c == curves - 1 && $urandom_range(0, 1)) begin
        cx[3] = fx;
        cy[3] = fy;
      end
      lx = cx[3];
      ly = cy[3];
      send(bpip_pkg::FUNC_APPEND, cx, cy, 0, 0);
    end
    hx = fx;
    hy = ly;
  endtask

  task automatic send_fields_zero();
    in_chan.ctrl0_x = '0;
    in_chan.ctrl0_y = '0;
    in_chan.ctrl1_x = '0;
    in_chan.ctrl1_y = '0;
    in_chan.ctrl2_x = '0;
    in_chan.ctrl2_y = '0;
    in_chan.ctrl3_x = '0;
    in_chan.ctrl3_y = '0;
    in_chan.query_x = '0;
    in_chan.query_y = '0;
  endtask

  initial begin
    coord_t cx[4], cy[4], z[4], hx, hy, qx, qy;
    int r;
    z = '{0, 0, 0, 0};
    cycles = 0;
    items = 0;
    burst_left = 0;
    steady_send = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = bpip_pkg::FUNC_CLEAR;
    send_fields_zero();
    out_chan.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed
    send(bpip_pkg::FUNC_QUERY, z, z, 16'sh7fff, 16'sh8000);
    send(FUNC_SPARE, z, z, 0, 0);
    cx = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    cy = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send(bpip_pkg::FUNC_APPEND, cx, cy, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 16'sh7fff, 16'sh8000);
    cx = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    cy = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send(bpip_pkg::FUNC_APPEND, cx, cy, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 16'sh8000, 16'sh7fff);
    send(bpip_pkg::FUNC_QUERY, z, z, 16'sh7fff, 0);
    send(FUNC_SPARE, cx, cy, 16'sh7fff, 16'sh7fff);
    send(bpip_pkg::FUNC_CLEAR, z, z, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 0, 0);
    cx = '{100, 100, 100, 100};
    cy = '{-40, -40, -40, -40};
    send(bpip_pkg::FUNC_APPEND, cx, cy, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 100, -40);
    send(bpip_pkg::FUNC_CLEAR, z, z, 0, 0);
    cx = '{0, 320, 320, 0};
    cy = '{0, 0, 320, 320};
    send(bpip_pkg::FUNC_APPEND, cx, cy, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 100, 160);
    send(bpip_pkg::FUNC_QUERY, z, z, 0, 0);
    send(bpip_pkg::FUNC_QUERY, z, z, 0, 320);
    send(bpip_pkg::FUNC_QUERY, z, z, 16'sh8000, 160);
    send(bpip_pkg::FUNC_QUERY, z, z, 400, 160);

    // hold off until the block has drained
    in_chan.valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);

    for (int round = 0; items < ITEM_TARGET; round++) begin
      steady_send = (round % 10) < 2;
      if (round == 20) begin
        // fill the store past its end
        send(bpip_pkg::FUNC_CLEAR, z, z, 0, 0);
        send_loop(70, 300, 0, hx, hy);
        send(bpip_pkg::FUNC_QUERY, z, z, hx, hy);
        send(bpip_pkg::FUNC_QUERY, z, z, near(hx, 200), near(hy, 200));
      end else if ($urandom_range(0, 9) == 0) begin
        for (int k = 0; k < 4; k++) begin
          cx[k] = coord_t'($urandom());
          cy[k] = coord_t'($urandom());
        end
        case ($urandom_range(0, 3))
          0: send(bpip_pkg::FUNC_CLEAR, cx, cy, coord_t'($urandom()), coord_t'($urandom()));
          1: send(bpip_pkg::FUNC_APPEND, cx, cy, coord_t'($urandom()), coord_t'($urandom()));
          2: send(bpip_pkg::FUNC_QUERY, cx, cy, coord_t'($urandom()), coord_t'($urandom()));
          default: send(FUNC_SPARE, cx, cy, coord_t'($urandom()), coord_t'($urandom()));
        endcase
      end else begin
        r = ($urandom_range(0, 3) == 0) ? 3000 : $urandom_range(4, 200);
        send(bpip_pkg::FUNC_CLEAR, z, z, 0, 0);
        send_loop($urandom_range(1, 5), r, $urandom_range(0, 7) == 0, hx, hy);
        repeat ($urandom_range(2, 6)) begin
          qx = near(hx, r);
          qy = $urandom_range(0, 2) == 0 ? hy : near(hy, r);
          send(bpip_pkg::FUNC_QUERY, z, z, qx, qy);
        end
      end
    end

    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
